/* rtl/core/humidity_temp_frame_checker_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame checker
// Shared property shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTFC_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTFC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/htfc_pkg.sv */
// ----------------------------------------------------------------------------
// htfc_pkg
// Types, constants and the CRC-8 helper of the sensor frame checker.
// ----------------------------------------------------------------------------
package htfc_pkg;

  localparam int unsigned THR_W    = 15;
  localparam int unsigned LIMIT_W  = 4;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned RUN_W    = 5;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;

  // Conversion scale factors (hundredths).
  localparam int unsigned TEMP_SPAN   = 17500;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned HUM_SPAN    = 10000;
  localparam int unsigned RAW_FULL    = 65535;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [THR_W-1:0]   THR_RESET       = 15'd300;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 4'd3;
  localparam logic [TEMP_W-1:0]  TEMP_LOW_RESET  = 15'h7060;  // -4000
  localparam logic [TEMP_W-1:0]  TEMP_HIGH_RESET = 15'd12500;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_HELD   = 3'd1,
    ST_FORCED = 3'd2,
    ST_CRC    = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LIMIT     = 2'd1,
    CFG_TEMP_LOW  = 2'd2,
    CFG_TEMP_HIGH = 2'd3
  } cfg_idx_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/core/humidity_temp_frame_checker_top.sv */
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker_top
// Checks six-byte sensor frames (CRC-8, range window, spike filter) and
// reports the held reading together with wrapping frame statistics.
//
//   Channel   Direction  Handshake            Beat
//   in_*      input      in_valid/in_ready    one raw frame
//   out_*     output     out_valid/out_ready  one status plus reading
//   cfg_*     input      cfg_we               one register write
//
// One frame per cycle is sustained unless the output stalls. The first stage
// checks both CRCs and forms the scaled products, the second divides by
// 65535, applies the window and the spike filter and updates the state. A
// stalled output holds the result and stops stage two; stage one still takes
// a beat while it is empty. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_checker_top_macros.svh"

module humidity_temp_frame_checker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [htfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htfc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_temp_msb,
  input  logic [7:0]                        in_temp_lsb,
  input  logic [7:0]                        in_temp_crc,
  input  logic [7:0]                        in_hum_msb,
  input  logic [7:0]                        in_hum_lsb,
  input  logic [7:0]                        in_hum_crc,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic signed [htfc_pkg::TEMP_W-1:0] out_temp_out,
  output logic [htfc_pkg::HUM_W-1:0]        out_hum_out,
  output logic                              out_reading_valid,
  output logic [htfc_pkg::RUN_W-1:0]        out_consecutive_anomalies,
  output logic [htfc_pkg::CNT_W-1:0]        out_anomaly_total,
  output logic [htfc_pkg::CNT_W-1:0]        out_frame_total,
  output logic [htfc_pkg::CNT_W-1:0]        out_error_total
);

  import htfc_pkg::*;

  // Configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [TEMP_W-1:0]  temp_low_r;
  logic [TEMP_W-1:0]  temp_high_r;

  // Stage one
  logic        s1_valid_r;
  logic        s1_crc_ok_r;
  logic [30:0] s1_prod_t_r;
  logic [29:0] s1_prod_h_r;
  logic        crc_ok_nxt;
  logic [30:0] prod_t_nxt;
  logic [29:0] prod_h_nxt;

  // Filter state and result register
  logic                     out_valid_r;
  logic                     have_valid_r, have_valid_nxt;
  logic [TEMP_W-1:0]        valid_temp_r, valid_temp_nxt;
  logic [HUM_W-1:0]         valid_hum_r, valid_hum_nxt;
  status_t                  status_r, status_nxt;
  logic [TEMP_W-1:0]        shown_temp_r, shown_temp_nxt;
  logic [HUM_W-1:0]         shown_hum_r, shown_hum_nxt;
  logic                     shown_valid_r, shown_valid_nxt;
  logic [RUN_W-1:0]         run_r, run_nxt;
  logic [CNT_W-1:0]         spike_cnt_r, spike_cnt_nxt;
  logic [CNT_W-1:0]         frame_cnt_r, frame_cnt_nxt;
  logic [CNT_W-1:0]         fail_cnt_r, fail_cnt_nxt;

  logic advance;
  logic fire;

  // Stage two datapath
  logic [14:0]        qt0;
  logic [16:0]        rt0;
  logic               t_wrap;
  logic [15:0]        ft;
  logic               rt_nz;
  logic signed [16:0] t_base;
  logic signed [16:0] t_val;
  logic signed [16:0] low_ext, high_ext;
  logic               in_window;
  logic [13:0]        qh0;
  logic [16:0]        rh0;
  logic [HUM_W-1:0]   h_val;
  logic signed [16:0] dt;
  logic [16:0]        adt;
  logic signed [15:0] dh;
  logic [15:0]        adh;
  logic               spike;
  logic [RUN_W-1:0]   run_inc;
  logic               forced;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      limit_r     <= LIMIT_RESET;
      temp_low_r  <= TEMP_LOW_RESET;
      temp_high_r <= TEMP_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        CFG_LIMIT:     limit_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_TEMP_LOW:  temp_low_r  <= cfg_wdata[TEMP_W-1:0];
        CFG_TEMP_HIGH: temp_high_r <= cfg_wdata[TEMP_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // --------------------------------------------------------------------------
  // Stage one: CRC check and scaling products
  // --------------------------------------------------------------------------
  always_comb begin
    crc_ok_nxt = (crc8_byte(crc8_byte(CRC_INIT, in_temp_msb), in_temp_lsb) == in_temp_crc)
              && (crc8_byte(crc8_byte(CRC_INIT, in_hum_msb), in_hum_lsb) == in_hum_crc);
    prod_t_nxt = 31'({in_temp_msb, in_temp_lsb}) * 31'(TEMP_SPAN);
    prod_h_nxt = 30'({in_hum_msb, in_hum_lsb}) * 30'(HUM_SPAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_crc_ok_r <= crc_ok_nxt;
      s1_prod_t_r <= prod_t_nxt;
      s1_prod_h_r <= prod_h_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage two: divide by 65535, window and spike filter
  // --------------------------------------------------------------------------
  // x = q*65536 + r = q*65535 + (q + r); the partial remainder stays below
  // twice the divisor, so one compare and subtract finishes the division.
  always_comb begin
    qt0    = s1_prod_t_r[30:16];
    rt0    = {1'b0, s1_prod_t_r[15:0]} + {2'b00, qt0};
    t_wrap = (rt0 >= 17'(RAW_FULL));
    ft     = {1'b0, qt0} + {15'd0, t_wrap};
    rt_nz  = t_wrap ? (rt0 != 17'(RAW_FULL)) : (rt0 != 17'd0);
    t_base = $signed({1'b0, ft}) - $signed(17'(TEMP_OFFSET));
    // Truncation toward zero rounds a negative quotient with a remainder up.
    t_val  = (t_base < 0 && rt_nz) ? t_base + 17'sd1 : t_base;

    low_ext   = 17'(signed'(temp_low_r));
    high_ext  = 17'(signed'(temp_high_r));
    in_window = (t_val >= low_ext) && (t_val <= high_ext);

    qh0   = s1_prod_h_r[29:16];
    rh0   = {1'b0, s1_prod_h_r[15:0]} + {3'b000, qh0};
    h_val = qh0 + {13'd0, (rh0 >= 17'(RAW_FULL))};

    dt  = t_val - 17'(signed'(valid_temp_r));
    adt = (dt < 0) ? 17'(-dt) : 17'(dt);
    dh  = $signed({2'b00, h_val}) - $signed({2'b00, valid_hum_r});
    adh = (dh < 0) ? 16'(-dh) : 16'(dh);
    spike = (adt > {2'b00, thr_r}) || (adh > {1'b0, thr_r});

    run_inc = (run_r == {RUN_W{1'b1}}) ? run_r : run_r + 1'b1;
    forced  = (run_inc > {1'b0, limit_r});
  end

  always_comb begin
    have_valid_nxt  = have_valid_r;
    valid_temp_nxt  = valid_temp_r;
    valid_hum_nxt   = valid_hum_r;
    status_nxt      = status_r;
    shown_temp_nxt  = shown_temp_r;
    shown_hum_nxt   = shown_hum_r;
    shown_valid_nxt = shown_valid_r;
    run_nxt         = run_r;
    spike_cnt_nxt   = spike_cnt_r;
    frame_cnt_nxt   = frame_cnt_r;
    fail_cnt_nxt    = fail_cnt_r;
    if (fire) begin
      frame_cnt_nxt = frame_cnt_r + 1'b1;
      if (!s1_crc_ok_r) begin
        status_nxt   = ST_CRC;
        fail_cnt_nxt = fail_cnt_r + 1'b1;
      end else if (!in_window) begin
        status_nxt   = ST_RANGE;
        fail_cnt_nxt = fail_cnt_r + 1'b1;
      end else begin
        status_nxt = ST_ACCEPT;
        if (have_valid_r && spike) begin
          spike_cnt_nxt = spike_cnt_r + 1'b1;
          if (forced) begin
            run_nxt    = '0;
            status_nxt = ST_FORCED;
          end else begin
            run_nxt    = run_inc;
            status_nxt = ST_HELD;
          end
        end else if (have_valid_r) begin
          run_nxt = '0;
        end
        if (status_nxt != ST_HELD) begin
          have_valid_nxt = 1'b1;
          valid_temp_nxt = t_val[TEMP_W-1:0];
          valid_hum_nxt  = h_val;
        end
        shown_temp_nxt  = valid_temp_nxt;
        shown_hum_nxt   = valid_hum_nxt;
        shown_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      have_valid_r  <= 1'b0;
      valid_temp_r  <= '0;
      valid_hum_r   <= '0;
      status_r      <= ST_ACCEPT;
      shown_temp_r  <= '0;
      shown_hum_r   <= '0;
      shown_valid_r <= 1'b0;
      run_r         <= '0;
      spike_cnt_r   <= '0;
      frame_cnt_r   <= '0;
      fail_cnt_r    <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      have_valid_r  <= have_valid_nxt;
      valid_temp_r  <= valid_temp_nxt;
      valid_hum_r   <= valid_hum_nxt;
      status_r      <= status_nxt;
      shown_temp_r  <= shown_temp_nxt;
      shown_hum_r   <= shown_hum_nxt;
      shown_valid_r <= shown_valid_nxt;
      run_r         <= run_nxt;
      spike_cnt_r   <= spike_cnt_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      fail_cnt_r    <= fail_cnt_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_status                = status_r;
  assign out_temp_out              = signed'(shown_temp_r);
  assign out_hum_out               = shown_hum_r;
  assign out_reading_valid         = shown_valid_r;
  assign out_consecutive_anomalies = run_r;
  assign out_anomaly_total         = spike_cnt_r;
  assign out_frame_total           = frame_cnt_r;
  assign out_error_total           = fail_cnt_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HTFC_ASSERT_NEXT(a_frame_count, fire, frame_cnt_r == $past(frame_cnt_r) + 1'b1, "frame count did not advance")
  `HTFC_ASSERT_NEXT(a_fail_count, fire, (status_r == ST_CRC || status_r == ST_RANGE) ? (fail_cnt_r == $past(fail_cnt_r) + 1'b1) : (fail_cnt_r == $past(fail_cnt_r)), "error count out of step with status")
  `HTFC_ASSERT_NEXT(a_held_keeps, fire, status_r != ST_HELD || ($stable(valid_temp_r) && $stable(valid_hum_r)), "held sample changed the valid reading")
  `HTFC_ASSERT_SAME(a_shown_valid, out_valid_r && (status_r == ST_ACCEPT || status_r == ST_FORCED), shown_temp_r == valid_temp_r && shown_hum_r == valid_hum_r && have_valid_r, "accepted reading not shown")

endmodule
